>>> hdl/rrts_pkg.sv
// Shared types, constants and codes for the round-robin task scheduler.
package rrts_pkg;

  localparam int MAX_TASKS        = 8;
  localparam int TICKS_PER_SWITCH = 10;

  localparam int ID_W      = $clog2(MAX_TASKS);
  localparam int COUNT_W   = $clog2(MAX_TASKS + 1);
  localparam int SLICE_W   = (TICKS_PER_SWITCH > 1) ? $clog2(TICKS_PER_SWITCH) : 1;
  localparam int FIELD_ID_W = 3;
  localparam int STATUS_W  = 3;
  localparam int OP_W      = 2;
  localparam int ADDR_W    = 32;
  localparam int BYTES_W   = 16;
  localparam int TICK_W    = 32;

  localparam logic [BYTES_W-1:0] MIN_STACK_RESET = 16'd64;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_ADD   = 2'd1,
    OP_END   = 2'd2,
    OP_START = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK           = 3'd0,
    STATUS_NOT_RUNNING  = 3'd1,
    STATUS_BAD_STACK    = 3'd2,
    STATUS_TABLE_FULL   = 3'd3,
    STATUS_CANNOT_START = 3'd4,
    STATUS_NO_READY     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    TASK_UNINIT  = 2'd0,
    TASK_READY   = 2'd1,
    TASK_RUNNING = 2'd2,
    TASK_DONE    = 2'd3
  } task_state_t;

  typedef enum logic [1:0] {
    CTL_IDLE   = 2'd0,
    CTL_EXEC   = 2'd1,
    CTL_SEARCH = 2'd2,
    CTL_EMIT   = 2'd3
  } ctl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic execute;
    logic search;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_search;
    logic search_done;
  } dp_status_t;

endpackage

>>> hdl/round_robin_task_scheduler.sv
// Top level of the round-robin task scheduler: controller plus datapath.
//
// Usage: one request on the input channel (op, stack_address, stack_bytes)
// gives exactly one result on the output channel (status, assigned_id,
// current_task, tick_total, switched). Both channels use valid/ready.
// The user must write min_stack_size via cfg_we/cfg_wdata only while the block
// is idle (not enforced by the block); it takes effect on the next request.
//
// Sequencing: a request is taken in the idle state and executed in the next
// cycle, and its result is then loaded into the output register in the emit
// state; a new request is taken only after that load. A tick that lands on a
// time-slice boundary also passes through the search state, which walks the
// task table one entry per cycle in round-robin order, at most MAX_TASKS
// entries (8 at the default size), before the emit state.
//
// Reset (rst, synchronous): all tasks uninitialized, no tasks added, kernel
// stopped, counters zero, min_stack_size back to 64, no result pending.
// Stall: a finished result holds in the output register while out_ready is
// low; the next request is still accepted and worked, and waits only at the
// final load step until the output register frees up.
module round_robin_task_scheduler (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rrts_pkg::BYTES_W-1:0]    cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rrts_pkg::OP_W-1:0]       op,
  input  logic [rrts_pkg::ADDR_W-1:0]     stack_address,
  input  logic [rrts_pkg::BYTES_W-1:0]    stack_bytes,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rrts_pkg::STATUS_W-1:0]   status,
  output logic [rrts_pkg::FIELD_ID_W-1:0] assigned_id,
  output logic [rrts_pkg::FIELD_ID_W-1:0] current_task,
  output logic [rrts_pkg::TICK_W-1:0]     tick_total,
  output logic                            switched
);
  import rrts_pkg::*;

  // Commands down, status up: the only link between control and data
  dp_cmd_t    cmd;
  dp_status_t stat;

  rrts_controller u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rrts_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .op            (op),
    .stack_address (stack_address),
    .stack_bytes   (stack_bytes),
    .cmd           (cmd),
    .stat          (stat),
    .status        (status),
    .assigned_id   (assigned_id),
    .current_task  (current_task),
    .tick_total    (tick_total),
    .switched      (switched)
  );

endmodule

>>> hdl/rrts_datapath.sv
// Task table, counters, round-robin search step and result registers.
module rrts_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rrts_pkg::BYTES_W-1:0]        cfg_wdata,
  input  logic [rrts_pkg::OP_W-1:0]           op,
  input  logic [rrts_pkg::ADDR_W-1:0]         stack_address,
  input  logic [rrts_pkg::BYTES_W-1:0]        stack_bytes,
  input  rrts_pkg::dp_cmd_t                   cmd,
  output rrts_pkg::dp_status_t                stat,
  output logic [rrts_pkg::STATUS_W-1:0]       status,
  output logic [rrts_pkg::FIELD_ID_W-1:0]     assigned_id,
  output logic [rrts_pkg::FIELD_ID_W-1:0]     current_task,
  output logic [rrts_pkg::TICK_W-1:0]         tick_total,
  output logic                                switched
);
  import rrts_pkg::*;

  task_state_t          task_state [MAX_TASKS];
  logic [COUNT_W-1:0]   task_count;
  logic [ID_W-1:0]      running_task;
  logic [TICK_W-1:0]    tick_count;
  logic [SLICE_W-1:0]   slice_count;
  logic                 kernel_running;
  logic [BYTES_W-1:0]   min_stack_size;

  op_t                  cur_op;
  logic [ADDR_W-1:0]    cur_addr;
  logic [BYTES_W-1:0]   cur_bytes;
  logic [ID_W-1:0]      search_id;
  logic [ID_W-1:0]      search_steps;
  status_t              res_status;
  logic [ID_W-1:0]      res_assigned;
  logic                 res_switched;

  logic [TICK_W-1:0]    tick_next;
  logic [SLICE_W-1:0]   slice_next;
  logic                 slice_wrap;
  logic                 switch_due;
  logic [ID_W-1:0]      probe_id;
  logic                 probe_ready;
  logic                 search_last;
  logic                 stack_bad;
  logic                 table_full;

  // The slice counter tracks tick_count modulo TICKS_PER_SWITCH; a 32-bit wrap
  // of the tick count lands on zero, so restart the slice there too.
  assign tick_next  = tick_count + TICK_W'(1);
  assign slice_wrap = (slice_count == SLICE_W'(TICKS_PER_SWITCH - 1));
  assign switch_due = (tick_next == '0) || slice_wrap;
  assign slice_next = switch_due ? '0 : slice_count + SLICE_W'(1);

  assign probe_id    = (search_id == ID_W'(MAX_TASKS - 1)) ? '0 : search_id + ID_W'(1);
  assign probe_ready = (task_state[probe_id] == TASK_READY);
  assign search_last = (search_steps == ID_W'(MAX_TASKS - 1));

  assign stack_bad  = (cur_addr == '0) || (cur_bytes <= min_stack_size);
  assign table_full = (task_count >= COUNT_W'(MAX_TASKS));

  assign stat.need_search = (cur_op == OP_TICK) && kernel_running && switch_due;
  assign stat.search_done = probe_ready || search_last;

  // Scheduler state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        task_state[i] <= TASK_UNINIT;
      end
      task_count     <= '0;
      running_task   <= '0;
      tick_count     <= '0;
      slice_count    <= '0;
      kernel_running <= 1'b0;
      min_stack_size <= MIN_STACK_RESET;
    end else begin
      if (cfg_we) begin
        min_stack_size <= cfg_wdata;
      end
      if (cmd.execute) begin
        unique case (cur_op)
          OP_TICK: begin
            if (kernel_running) begin
              tick_count  <= tick_next;
              slice_count <= slice_next;
              if (switch_due && task_state[running_task] == TASK_RUNNING) begin
                task_state[running_task] <= TASK_READY;
              end
            end
          end
          OP_ADD: begin
            if (!stack_bad && !table_full) begin
              task_state[task_count[ID_W-1:0]] <= TASK_READY;
              task_count <= task_count + COUNT_W'(1);
            end
          end
          OP_END: begin
            if (kernel_running) begin
              task_state[running_task] <= TASK_DONE;
            end
          end
          OP_START: begin
            if (!kernel_running && task_count != '0) begin
              running_task   <= '0;
              task_state[0]  <= TASK_RUNNING;
              kernel_running <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (cmd.search && probe_ready) begin
        task_state[probe_id] <= TASK_RUNNING;
        running_task         <= probe_id;
      end
    end
  end

  // Request capture, search pointer and result registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_op    <= op_t'(op);
      cur_addr  <= stack_address;
      cur_bytes <= stack_bytes;
    end
    if (cmd.execute) begin
      res_status   <= STATUS_OK;
      res_assigned <= '0;
      res_switched <= 1'b0;
      search_id    <= running_task;
      search_steps <= '0;
      unique case (cur_op)
        OP_TICK: begin
          if (!kernel_running) begin
            res_status <= STATUS_NOT_RUNNING;
          end
        end
        OP_ADD: begin
          priority if (stack_bad) begin
            res_status <= STATUS_BAD_STACK;
          end else if (table_full) begin
            res_status <= STATUS_TABLE_FULL;
          end else begin
            res_assigned <= task_count[ID_W-1:0];
          end
        end
        OP_END: begin
          if (!kernel_running) begin
            res_status <= STATUS_NOT_RUNNING;
          end
        end
        OP_START: begin
          if (kernel_running || task_count == '0) begin
            res_status <= STATUS_CANNOT_START;
          end
        end
        default: ;
      endcase
    end
    if (cmd.search) begin
      priority if (probe_ready) begin
        res_switched <= 1'b1;
      end else if (search_last) begin
        res_status <= STATUS_NO_READY;
      end else begin
        search_id    <= probe_id;
        search_steps <= search_steps + ID_W'(1);
      end
    end
    if (cmd.load_out) begin
      status       <= res_status;
      assigned_id  <= FIELD_ID_W'(res_assigned);
      current_task <= FIELD_ID_W'(running_task);
      tick_total   <= tick_count;
      switched     <= res_switched;
    end
  end

endmodule

>>> hdl/rrts_controller.sv
// Sequencing state machine and output valid flag for the task scheduler.
module rrts_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  rrts_pkg::dp_status_t stat,
  output rrts_pkg::dp_cmd_t    cmd
);
  import rrts_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CTL_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      priority if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      CTL_IDLE:   if (in_valid) state_next = CTL_EXEC;
      CTL_EXEC:   state_next = stat.need_search ? CTL_SEARCH : CTL_EMIT;
      CTL_SEARCH: if (stat.search_done) state_next = CTL_EMIT;
      CTL_EMIT:   if (out_free) state_next = CTL_IDLE;
      default:    state_next = CTL_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state == CTL_IDLE);
    cmd.capture  = (state == CTL_IDLE) && in_valid;
    cmd.execute  = (state == CTL_EXEC);
    cmd.search   = (state == CTL_SEARCH);
    cmd.load_out = (state == CTL_EMIT) && out_free;
  end

endmodule

>>> bench/sched_checker.sv
// Checker for the round-robin task scheduler: tracks task state and compares every result.
`timescale 1ns / 1ps

module sched_checker
  import rrts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [BYTES_W-1:0]    cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [OP_W-1:0]       op,
  input  logic [ADDR_W-1:0]     stack_address,
  input  logic [BYTES_W-1:0]    stack_bytes,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [STATUS_W-1:0]   status,
  input  logic [FIELD_ID_W-1:0] assigned_id,
  input  logic [FIELD_ID_W-1:0] current_task,
  input  logic [TICK_W-1:0]     tick_total,
  input  logic                  switched,
  output int                    fail_count,
  output int                    outstanding
);

  typedef struct packed {
    status_t               status;
    logic [FIELD_ID_W-1:0] assigned_id;
    logic [FIELD_ID_W-1:0] current_task;
    logic [TICK_W-1:0]     tick_total;
    logic                  switched;
  } sched_reply_t;

  // Shadow copy of the scheduler state
  task_state_t        task_tbl [MAX_TASKS];
  int                 task_count;
  int                 running_id;
  logic [TICK_W-1:0]  tick_count;
  logic               kernel_on;
  logic [BYTES_W-1:0] min_stack;

  sched_reply_t replies [$];
  sched_reply_t want;
  int           errors = 0;

  assign fail_count = errors;

  // Apply one event to the shadow state and return the reply it should produce.
  function automatic sched_reply_t schedule_event(op_t ev, logic [ADDR_W-1:0] addr,
                                                  logic [BYTES_W-1:0] bytes);
    sched_reply_t r;
    int           id;
    bit           found;
    r = '0;
    r.status = STATUS_OK;
    case (ev)
      OP_TICK: begin
        if (!kernel_on) begin
          r.status = STATUS_NOT_RUNNING;
        end else begin
          tick_count = tick_count + 1'b1;
          if (tick_count % TICKS_PER_SWITCH == 0) begin
            // demote the running task, then search forward for the next ready one
            id = running_id % MAX_TASKS;
            if (task_tbl[id] == TASK_RUNNING) task_tbl[id] = TASK_READY;
            found = 1'b0;
            for (int n = 0; n < MAX_TASKS && !found; n++) begin
              id = (id + 1) % MAX_TASKS;
              if (task_tbl[id] == TASK_READY) begin
                task_tbl[id] = TASK_RUNNING;
                running_id = id;
                found = 1'b1;
              end
            end
            if (found) r.switched = 1'b1;
            else r.status = STATUS_NO_READY;
          end
        end
      end
      OP_ADD: begin
        if (addr == '0 || bytes <= min_stack) begin
          r.status = STATUS_BAD_STACK;
        end else if (task_count >= MAX_TASKS) begin
          r.status = STATUS_TABLE_FULL;
        end else begin
          task_tbl[task_count] = TASK_READY;
          r.assigned_id = FIELD_ID_W'(task_count);
          task_count++;
        end
      end
      OP_END: begin
        if (!kernel_on) r.status = STATUS_NOT_RUNNING;
        else task_tbl[running_id % MAX_TASKS] = TASK_DONE;
      end
      default: begin
        if (kernel_on || task_count == 0) begin
          r.status = STATUS_CANNOT_START;
        end else begin
          running_id = 0;
          task_tbl[0] = TASK_RUNNING;
          kernel_on = 1'b1;
        end
      end
    endcase
    r.current_task = FIELD_ID_W'(running_id);
    r.tick_total = tick_count;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp, act);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (task_tbl[i]) task_tbl[i] = TASK_UNINIT;
      task_count = 0;
      running_id = 0;
      tick_count = '0;
      kernel_on = 1'b0;
      min_stack = MIN_STACK_RESET;
      replies.delete();
      outstanding <= 0;
    end else begin
      if (cfg_we) min_stack = cfg_wdata;
      if (in_valid && in_ready)
        replies.push_back(schedule_event(op_t'(op), stack_address, stack_bytes));
      if (out_valid && out_ready) begin
        if (replies.size() == 0) begin
          $display("%0t: result with no request pending, status %0d", $time, status);
          errors++;
        end else begin
          want = replies.pop_front();
          check_field("status", want.status, status);
          check_field("assigned_id", want.assigned_id, assigned_id);
          check_field("current_task", want.current_task, current_task);
          check_field("tick_total", want.tick_total, tick_total);
          check_field("switched", want.switched, switched);
        end
      end
      outstanding <= replies.size();
    end
  end

endmodule

>>> bench/tb_top.sv
// Top-level bench for the round-robin task scheduler: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import rrts_pkg::*;

  // Cycles to wait after the last result before a register write or the verdict;
  // covers the execute step plus a full round-robin search.
  localparam int SETTLE_CYCLES = 3 * MAX_TASKS;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [BYTES_W-1:0]    cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  op_t                   op = OP_TICK;
  logic [ADDR_W-1:0]     stack_address = '0;
  logic [BYTES_W-1:0]    stack_bytes = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [FIELD_ID_W-1:0] assigned_id;
  logic [FIELD_ID_W-1:0] current_task;
  logic [TICK_W-1:0]     tick_total;
  logic                  switched;

  int fail_count;
  int outstanding;

  // Idle percentages of the request side and the result side
  int send_idle = 0;
  int recv_idle = 0;

  // Mirror of min_stack_size, used to aim stack sizes at the boundary
  logic [BYTES_W-1:0] cur_min = MIN_STACK_RESET;

  initial begin
    forever #2 clk = ~clk;
  end

  round_robin_task_scheduler u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .stack_address (stack_address),
    .stack_bytes   (stack_bytes),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .assigned_id   (assigned_id),
    .current_task  (current_task),
    .tick_total    (tick_total),
    .switched      (switched)
  );

  sched_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .stack_address (stack_address),
    .stack_bytes   (stack_bytes),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .assigned_id   (assigned_id),
    .current_task  (current_task),
    .tick_total    (tick_total),
    .switched      (switched),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  // Stall the result side at random; one assignment per edge.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Offer one request and hold it until accepted. Valid is dropped only for an
  // idle gap, so a back-to-back request never lowers and raises it in one step.
  task automatic send_req(op_t ev, logic [ADDR_W-1:0] addr, logic [BYTES_W-1:0] bytes);
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    in_valid      <= 1'b1;
    op            <= ev;
    stack_address <= addr;
    stack_bytes   <= bytes;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and wait until every request has produced its result, then let
  // the block settle before touching the register or giving the verdict.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write min_stack_size; only called while the block is idle.
  task automatic write_min_stack(logic [BYTES_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    cur_min = value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random requests: mostly ticks so the time slices keep turning, a fair share
  // of adds aimed at the stack-size boundary, a few starts and rare ends so the
  // table is not all done too early.
  task automatic run_random(int count);
    op_t                ev;
    logic [ADDR_W-1:0]  addr;
    logic [BYTES_W-1:0] bytes;
    int                 pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 999);
      if (pick < 750) ev = OP_TICK;
      else if (pick < 930) ev = OP_ADD;
      else if (pick < 990) ev = OP_START;
      else ev = OP_END;
      addr = ($urandom_range(0, 9) == 0) ? '0 : ADDR_W'($urandom);
      case ($urandom_range(0, 9))
        0:       bytes = '0;
        1:       bytes = '1;
        2, 3:    bytes = cur_min;
        4, 5:    bytes = cur_min + 1'b1;
        default: bytes = BYTES_W'($urandom);
      endcase
      send_req(ev, addr, bytes);
    end
  endtask

  initial begin
    // Hold reset once, at the start
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_idle = 17;
    recv_idle = 51;

    // Directed: events while stopped, start with an empty table
    send_req(OP_TICK, 32'h0, 16'h0);
    send_req(OP_END, 32'hFFFF_FFFF, 16'hFFFF);
    send_req(OP_START, 32'h0, 16'h0);
    // Stack checks at the reset minimum: absent address, size equal to minimum
    send_req(OP_ADD, 32'h0, 16'hFFFF);
    send_req(OP_ADD, 32'h1, MIN_STACK_RESET);
    // Smallest accepted size at the largest address, then the largest size
    send_req(OP_ADD, 32'hFFFF_FFFF, MIN_STACK_RESET + 1'b1);
    send_req(OP_ADD, 32'h8000_0000, 16'hFFFF);
    // Start, then start again while running
    send_req(OP_START, 32'h0, 16'h0);
    send_req(OP_START, 32'h0, 16'h0);
    // End task 0, then run a full time slice so the switch skips it
    send_req(OP_END, 32'h0, 16'h0);
    repeat (TICKS_PER_SWITCH) send_req(OP_TICK, ADDR_W'($urandom), BYTES_W'($urandom));
    // Add while running
    send_req(OP_ADD, 32'h0000_1000, 16'h0100);
    send_req(OP_ADD, 32'h0000_2000, 16'h7FFF);
    drain();

    // Lowest minimum: any nonzero size passes
    write_min_stack(16'h0000);
    run_random(500);
    drain();

    // Swap the idle pattern; highest minimum: every add fails the stack check
    send_idle = 51;
    recv_idle = 17;
    write_min_stack(16'hFFFF);
    run_random(500);
    drain();

    // No idling at all; a random minimum
    send_idle = 0;
    recv_idle = 0;
    write_min_stack(BYTES_W'($urandom_range(1, 65534)));
    run_random(500);
    drain();

    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
